>>> rtl/sdf_pkg.sv
// shared constants, types and state encoding for the snapshot delta filter
`default_nettype none
package sdf_pkg;

  localparam int CacheEntries = 256;
  localparam int PendDepth    = 32;

  localparam int IdxW     = $clog2(CacheEntries);
  localparam int PendW    = $clog2(PendDepth + 1);
  localparam int PendIdxW = (PendDepth > 1) ? $clog2(PendDepth) : 1;
  localparam int StW      = 5 * 64 + 32;

  localparam logic [IdxW:0]  ScanEnd  = (IdxW + 1)'(CacheEntries);
  localparam logic [PendW-1:0] PendMax = PendW'(PendDepth);

  localparam logic [1:0] KindState   = 2'd0;
  localparam logic [1:0] KindDespawn = 2'd1;
  localparam logic [1:0] KindEnd     = 2'd2;

  typedef enum logic [3:0] {
    StIdle,
    StLkChk,
    StLkCmp,
    StStRd,
    StStCmp,
    StLkEnd,
    StEmitSt,
    StSwChk,
    StSwPush,
    StFlChk,
    StFlEmit,
    StEndEmit
  } ctrl_state_e;

  typedef struct packed {
    logic cap;
    logic scan_inc;
    logic rd_id;
    logic note_free;
    logic set_found;
    logic rd_st;
    logic set_seen_hit;
    logic wr_st_hit;
    logic ins_free;
    logic clr_slot;
    logic clr_seen;
    logic push;
    logic fl_clr;
    logic fl_inc;
    logic rd_pend;
    logic load_st;
    logic load_desp;
    logic load_end;
  } sdf_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic cur_valid;
    logic cur_seen;
    logic id_match;
    logic st_equal;
    logic is_end;
    logic interest;
    logic full;
    logic fl_more;
    logic out_free;
  } sdf_status_t;

endpackage
`default_nettype wire

>>> rtl/sdf_ctrl.sv
// controller state machine sequencing lookup, sweep and flush
`default_nettype none
module sdf_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire sdf_pkg::sdf_status_t sts_i,
  output sdf_pkg::sdf_cmd_t       cmd_o
);

  sdf_pkg::ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sdf_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      sdf_pkg::StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = sdf_pkg::StLkChk;
        end
      end
      sdf_pkg::StLkChk: begin
        // entered after capture, this state also routes end markers and skipped items
        if (sts_i.is_end) begin
          state_d = sdf_pkg::StSwChk;
        end else if (!sts_i.interest) begin
          state_d = sdf_pkg::StIdle;
        end else if (sts_i.scan_done) begin
          state_d = sdf_pkg::StLkEnd;
        end else if (sts_i.cur_valid) begin
          cmd_o.rd_id = 1'b1;
          state_d     = sdf_pkg::StLkCmp;
        end else begin
          cmd_o.note_free = 1'b1;
          cmd_o.scan_inc  = 1'b1;
        end
      end
      sdf_pkg::StLkCmp: begin
        if (sts_i.id_match) begin
          cmd_o.set_found = 1'b1;
          state_d         = sdf_pkg::StStRd;
        end else begin
          cmd_o.scan_inc = 1'b1;
          state_d        = sdf_pkg::StLkChk;
        end
      end
      sdf_pkg::StStRd: begin
        cmd_o.rd_st = 1'b1;
        state_d     = sdf_pkg::StStCmp;
      end
      sdf_pkg::StStCmp: begin
        cmd_o.set_seen_hit = 1'b1;
        if (sts_i.st_equal) begin
          state_d = sts_i.full ? sdf_pkg::StEmitSt : sdf_pkg::StIdle;
        end else begin
          cmd_o.wr_st_hit = 1'b1;
          state_d         = sdf_pkg::StEmitSt;
        end
      end
      sdf_pkg::StLkEnd: begin
        cmd_o.ins_free = 1'b1;
        state_d        = sdf_pkg::StEmitSt;
      end
      sdf_pkg::StEmitSt: begin
        if (sts_i.out_free) begin
          cmd_o.load_st = 1'b1;
          state_d       = sdf_pkg::StIdle;
        end
      end
      sdf_pkg::StSwChk: begin
        if (sts_i.scan_done) begin
          cmd_o.fl_clr = 1'b1;
          state_d      = sdf_pkg::StFlChk;
        end else if (sts_i.cur_valid && !sts_i.cur_seen) begin
          cmd_o.rd_id = 1'b1;
          state_d     = sdf_pkg::StSwPush;
        end else begin
          cmd_o.clr_seen = 1'b1;
          cmd_o.scan_inc = 1'b1;
        end
      end
      sdf_pkg::StSwPush: begin
        cmd_o.clr_slot = 1'b1;
        cmd_o.push     = 1'b1;
        cmd_o.scan_inc = 1'b1;
        state_d        = sdf_pkg::StSwChk;
      end
      sdf_pkg::StFlChk: begin
        if (sts_i.fl_more) begin
          cmd_o.rd_pend = 1'b1;
          state_d       = sdf_pkg::StFlEmit;
        end else begin
          state_d = sdf_pkg::StEndEmit;
        end
      end
      sdf_pkg::StFlEmit: begin
        if (sts_i.out_free) begin
          cmd_o.load_desp = 1'b1;
          cmd_o.fl_inc    = 1'b1;
          state_d         = sdf_pkg::StFlChk;
        end
      end
      sdf_pkg::StEndEmit: begin
        if (sts_i.out_free) begin
          cmd_o.load_end = 1'b1;
          state_d        = sdf_pkg::StIdle;
        end
      end
      default: state_d = sdf_pkg::StIdle;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/sdf_datapath.sv
// slot table, pending list, counters and output register
`default_nettype none
module sdf_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire sdf_pkg::sdf_cmd_t  cmd_i,
  output sdf_pkg::sdf_status_t    sts_o,
  input  wire logic               action_i,
  input  wire logic [63:0]        net_id_i,
  input  wire logic               in_interest_i,
  input  wire logic               full_req_i,
  input  wire logic [63:0]        pos_xy_i,
  input  wire logic [63:0]        pos_z_scale_i,
  input  wire logic [63:0]        rot_xy_i,
  input  wire logic [63:0]        rot_zw_i,
  input  wire logic [63:0]        mesh_hash_i,
  input  wire logic [31:0]        user_tag_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [1:0]              kind_o,
  output logic [63:0]             out_id_o,
  output logic [63:0]             out_pos_xy_o,
  output logic [63:0]             out_pos_z_scale_o,
  output logic [63:0]             out_rot_xy_o,
  output logic [63:0]             out_rot_zw_o,
  output logic [63:0]             out_mesh_o,
  output logic [31:0]             out_tag_o,
  output logic [15:0]             entity_count_o,
  output logic                    despawn_overflow_o,
  output logic                    last_o
);

  localparam int IdxW     = sdf_pkg::IdxW;
  localparam int PendW    = sdf_pkg::PendW;
  localparam int PendIdxW = sdf_pkg::PendIdxW;
  localparam int StW      = sdf_pkg::StW;

  // memories
  logic [63:0]    id_mem   [sdf_pkg::CacheEntries];
  logic [StW-1:0] st_mem   [sdf_pkg::CacheEntries];
  logic [63:0]    pend_mem [sdf_pkg::PendDepth];

  logic [sdf_pkg::CacheEntries-1:0] valid_q, seen_q;
  logic [63:0]    id_rd_q, pend_rd_q;
  logic [StW-1:0] st_rd_q;

  // captured item
  logic           end_q, interest_q, full_q;
  logic [63:0]    id_q;
  logic [StW-1:0] st_q;

  logic [IdxW:0]    scan_q;
  logic [IdxW-1:0]  hit_q, free_q;
  logic             have_free_q;
  logic [PendW-1:0] pend_cnt_q, fl_q;
  logic [15:0]      emit_cnt_q;
  logic             ovf_q;
  logic [IdxW-1:0]  cur;
  logic [IdxW-1:0]  st_wr_addr;

  assign cur        = scan_q[IdxW-1:0];
  assign st_wr_addr = cmd_i.ins_free ? free_q : hit_q;

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      end_q      <= action_i;
      interest_q <= in_interest_i;
      full_q     <= full_req_i;
      id_q       <= net_id_i;
      st_q       <= {pos_xy_i, pos_z_scale_i, rot_xy_i, rot_zw_i, mesh_hash_i, user_tag_i};
    end
  end

  // slot table memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_id) begin
      id_rd_q <= id_mem[cur];
    end
    if (cmd_i.rd_st) begin
      st_rd_q <= st_mem[hit_q];
    end
    if (cmd_i.ins_free && have_free_q) begin
      id_mem[free_q] <= id_q;
    end
    if (cmd_i.wr_st_hit || (cmd_i.ins_free && have_free_q)) begin
      st_mem[st_wr_addr] <= st_q;
    end
  end

  // pending list memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_pend) begin
      pend_rd_q <= pend_mem[fl_q[PendIdxW-1:0]];
    end
    if (cmd_i.push && (pend_cnt_q < sdf_pkg::PendMax)) begin
      pend_mem[pend_cnt_q[PendIdxW-1:0]] <= id_rd_q;
    end
  end

  // valid and seen bits, scan and lookup bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      seen_q      <= '0;
      scan_q      <= '0;
      hit_q       <= '0;
      free_q      <= '0;
      have_free_q <= 1'b0;
    end else begin
      if (cmd_i.cap) begin
        scan_q      <= '0;
        have_free_q <= 1'b0;
      end else if (cmd_i.scan_inc) begin
        scan_q <= scan_q + 1'b1;
      end
      if (cmd_i.note_free && !have_free_q) begin
        have_free_q <= 1'b1;
        free_q      <= cur;
      end
      if (cmd_i.set_found) begin
        hit_q <= cur;
      end
      if (cmd_i.set_seen_hit) begin
        seen_q[hit_q] <= 1'b1;
      end
      if (cmd_i.ins_free && have_free_q) begin
        valid_q[free_q] <= 1'b1;
        seen_q[free_q]  <= 1'b1;
      end
      if (cmd_i.clr_seen) begin
        seen_q[cur] <= 1'b0;
      end
      if (cmd_i.clr_slot) begin
        valid_q[cur] <= 1'b0;
        seen_q[cur]  <= 1'b0;
      end
    end
  end

  // pending count, flush index, emitted count, overflow
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_cnt_q <= '0;
      fl_q       <= '0;
      emit_cnt_q <= '0;
      ovf_q      <= 1'b0;
    end else begin
      if (cmd_i.push) begin
        if (pend_cnt_q < sdf_pkg::PendMax) begin
          pend_cnt_q <= pend_cnt_q + 1'b1;
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.fl_clr) begin
        fl_q <= '0;
      end else if (cmd_i.fl_inc) begin
        fl_q <= fl_q + 1'b1;
      end
      if (cmd_i.load_st && (emit_cnt_q != 16'hFFFF)) begin
        emit_cnt_q <= emit_cnt_q + 1'b1;
      end
      if (cmd_i.load_end) begin
        emit_cnt_q <= '0;
        if (full_q) begin
          pend_cnt_q <= '0;
          ovf_q      <= 1'b0;
        end
      end
    end
  end

  // output register
  logic load;
  assign load = cmd_i.load_st || cmd_i.load_desp || cmd_i.load_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_o             <= cmd_i.load_st ? sdf_pkg::KindState :
                            cmd_i.load_desp ? sdf_pkg::KindDespawn : sdf_pkg::KindEnd;
      out_id_o           <= cmd_i.load_st ? id_q : (cmd_i.load_desp ? pend_rd_q : 64'd0);
      {out_pos_xy_o, out_pos_z_scale_o, out_rot_xy_o, out_rot_zw_o, out_mesh_o, out_tag_o}
                         <= cmd_i.load_st ? st_q : '0;
      entity_count_o     <= cmd_i.load_end ? emit_cnt_q : 16'd0;
      despawn_overflow_o <= cmd_i.load_end & ovf_q;
      last_o             <= cmd_i.load_st | cmd_i.load_end;
    end
  end

  // status to controller
  always_comb begin
    sts_o.scan_done = (scan_q == sdf_pkg::ScanEnd);
    sts_o.cur_valid = valid_q[cur];
    sts_o.cur_seen  = seen_q[cur];
    sts_o.id_match  = (id_rd_q == id_q);
    sts_o.st_equal  = (st_rd_q == st_q);
    sts_o.is_end    = end_q;
    sts_o.interest  = interest_q;
    sts_o.full      = full_q;
    sts_o.fl_more   = (fl_q < pend_cnt_q);
    sts_o.out_free  = !out_valid_o || !out_stall_i;
  end

endmodule
`default_nettype wire

>>> rtl/snapshot_delta_filter_core.sv
// top level of the snapshot delta filter
// Usage: one item on the input channel is an entity record (action 0) or an
// end-of-capture marker (action 1). Items are taken when in_valid_i is high
// and in_stall_o is low; in_stall_o is low only while the block is idle.
// A record walks the slot table one slot per cycle for free slots; a valid
// slot takes an id memory read, then a compare, and the walk stops at a
// hit; a hit adds a state read and compare. A record out of interest is
// dropped without a scan, and a miss scans the whole table serially.
// An end marker sweeps all slots, putting unseen valid ones into the
// pending list, then sends one despawn item per pending id and a closing
// end item with the entity count.
// Results leave through a single output register: out_valid_o holds with
// its payload while out_stall_i is high, and the block waits for room
// before loading the next result. last_o marks the final result of an item.
// Reset (rst_ni low, asynchronous) clears all valid and seen bits, the
// pending count, the entity count and the overflow flag at once; there is
// no clearing pass and the block is ready as soon as reset is released.
`default_nettype none
module snapshot_delta_filter_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        action_i,
  input  wire logic [63:0] net_id_i,
  input  wire logic        in_interest_i,
  input  wire logic        full_req_i,
  input  wire logic [63:0] pos_xy_i,
  input  wire logic [63:0] pos_z_scale_i,
  input  wire logic [63:0] rot_xy_i,
  input  wire logic [63:0] rot_zw_i,
  input  wire logic [63:0] mesh_hash_i,
  input  wire logic [31:0] user_tag_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [63:0]      out_id_o,
  output logic [63:0]      out_pos_xy_o,
  output logic [63:0]      out_pos_z_scale_o,
  output logic [63:0]      out_rot_xy_o,
  output logic [63:0]      out_rot_zw_o,
  output logic [63:0]      out_mesh_o,
  output logic [31:0]      out_tag_o,
  output logic [15:0]      entity_count_o,
  output logic             despawn_overflow_o,
  output logic             last_o
);

  sdf_pkg::sdf_cmd_t    cmd;
  sdf_pkg::sdf_status_t sts;

  // controller
  sdf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  sdf_datapath u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .action_i           (action_i),
    .net_id_i           (net_id_i),
    .in_interest_i      (in_interest_i),
    .full_req_i         (full_req_i),
    .pos_xy_i           (pos_xy_i),
    .pos_z_scale_i      (pos_z_scale_i),
    .rot_xy_i           (rot_xy_i),
    .rot_zw_i           (rot_zw_i),
    .mesh_hash_i        (mesh_hash_i),
    .user_tag_i         (user_tag_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .kind_o             (kind_o),
    .out_id_o           (out_id_o),
    .out_pos_xy_o       (out_pos_xy_o),
    .out_pos_z_scale_o  (out_pos_z_scale_o),
    .out_rot_xy_o       (out_rot_xy_o),
    .out_rot_zw_o       (out_rot_zw_o),
    .out_mesh_o         (out_mesh_o),
    .out_tag_o          (out_tag_o),
    .entity_count_o     (entity_count_o),
    .despawn_overflow_o (despawn_overflow_o),
    .last_o             (last_o)
  );

endmodule
`default_nettype wire

>>> rtl/sdf_checker.sv
// port-level checker for the snapshot delta filter, bound to the top level
`default_nettype none
module sdf_props (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [1:0]  kind_o,
  input wire logic [63:0] out_id_o,
  input wire logic [15:0] entity_count_o,
  input wire logic        despawn_overflow_o,
  input wire logic        last_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_id_o) && $stable(kind_o))
    else $error("stalled result changed");

  // end item always closes its item
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == sdf_pkg::KindEnd) |-> last_o)
    else $error("end item without last");

  // despawn items never close an item
  a_desp_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == sdf_pkg::KindDespawn) |-> !last_o)
    else $error("despawn item marked last");

  // count and overflow only on end items
  a_count_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != sdf_pkg::KindEnd) |-> (entity_count_o == 16'd0) &&
    !despawn_overflow_o)
    else $error("count shown outside end item");

endmodule

bind snapshot_delta_filter_core sdf_props u_sdf_props (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .kind_o             (kind_o),
  .out_id_o           (out_id_o),
  .entity_count_o     (entity_count_o),
  .despawn_overflow_o (despawn_overflow_o),
  .last_o             (last_o)
);
`default_nettype wire

>>> bench/sdf_checker.sv
// checker for the snapshot delta filter: predicts results and compares them
module sdf_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire logic        action_i,
  input  wire logic [63:0] net_id_i,
  input  wire logic        in_interest_i,
  input  wire logic        full_req_i,
  input  wire logic [63:0] pos_xy_i,
  input  wire logic [63:0] pos_z_scale_i,
  input  wire logic [63:0] rot_xy_i,
  input  wire logic [63:0] rot_zw_i,
  input  wire logic [63:0] mesh_hash_i,
  input  wire logic [31:0] user_tag_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire logic [1:0]  kind_i,
  input  wire logic [63:0] out_id_i,
  input  wire logic [63:0] out_pos_xy_i,
  input  wire logic [63:0] out_pos_z_scale_i,
  input  wire logic [63:0] out_rot_xy_i,
  input  wire logic [63:0] out_rot_zw_i,
  input  wire logic [63:0] out_mesh_i,
  input  wire logic [31:0] out_tag_i,
  input  wire logic [15:0] entity_count_i,
  input  wire logic        despawn_overflow_i,
  input  wire logic        last_i,
  output int               fail_count_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [63:0] pxy;
    logic [63:0] pzs;
    logic [63:0] rxy;
    logic [63:0] rzw;
    logic [63:0] mesh;
    logic [31:0] tag;
  } ent_state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] id;
    ent_state_t  st;
    logic [15:0] cnt;
    logic        ovf;
    logic        last;
  } sdf_result_t;

  // shadow copy of the block's table and lists
  logic        shadow_valid [sdf_pkg::CacheEntries];
  logic        shadow_seen  [sdf_pkg::CacheEntries];
  logic [63:0] shadow_id    [sdf_pkg::CacheEntries];
  ent_state_t  shadow_st    [sdf_pkg::CacheEntries];
  logic [63:0] shadow_pend  [sdf_pkg::PendDepth];
  int          shadow_npend;
  int          shadow_emitted;
  logic        shadow_ovf;

  sdf_result_t expected_results[$];
  int fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_results.size();

  function automatic sdf_result_t mk_result(logic [1:0] k, logic [63:0] id,
                                            ent_state_t st, logic [15:0] c,
                                            logic o);
    sdf_result_t r;
    r.kind = k; r.id = id; r.st = st; r.cnt = c; r.ovf = o; r.last = 1'b0;
    return r;
  endfunction

  // append one expected result
  task automatic queue_result(sdf_result_t r);
    expected_results = {expected_results, r};
  endtask

  // filter one item and queue the results it causes
  task automatic filter_item(logic act, logic [63:0] id, logic intr, logic full,
                             ent_state_t st);
    int hit, fr, n;
    sdf_result_t r;
    hit = -1; fr = -1; n = 0;
    if (act) begin
      for (int s = 0; s < sdf_pkg::CacheEntries; s++) begin
        if (shadow_valid[s] && !shadow_seen[s]) begin
          shadow_valid[s] = 1'b0;
          if (shadow_npend < sdf_pkg::PendDepth) begin
            shadow_pend[shadow_npend] = shadow_id[s];
            shadow_npend++;
          end else shadow_ovf = 1'b1;
        end
        shadow_seen[s] = 1'b0;
      end
      for (int i = 0; i < shadow_npend; i++)
        queue_result(mk_result(sdf_pkg::KindDespawn, shadow_pend[i], '0, '0, 1'b0));
      r = mk_result(sdf_pkg::KindEnd, '0, '0, shadow_emitted[15:0], shadow_ovf);
      r.last = 1'b1;
      queue_result(r);
      shadow_emitted = 0;
      if (full) begin
        shadow_npend = 0;
        shadow_ovf = 1'b0;
      end
      return;
    end
    if (!intr) return;
    for (int s = 0; s < sdf_pkg::CacheEntries; s++) begin
      if (shadow_valid[s]) begin
        if (hit < 0 && shadow_id[s] == id) hit = s;
      end else if (fr < 0) fr = s;
    end
    if (hit < 0) begin
      if (fr >= 0) begin
        shadow_valid[fr] = 1'b1; shadow_seen[fr] = 1'b1;
        shadow_id[fr] = id; shadow_st[fr] = st;
      end
      n = 1;
    end else begin
      shadow_seen[hit] = 1'b1;
      if (shadow_st[hit] != st) begin
        shadow_st[hit] = st;
        n = 1;
      end else if (full) n = 1;
    end
    if (n > 0) begin
      r = mk_result(sdf_pkg::KindState, id, st, '0, 1'b0);
      r.last = 1'b1;
      queue_result(r);
      if (shadow_emitted < 65535) shadow_emitted++;
    end
  endtask

  initial begin
    fails = 0;
    shadow_npend = 0; shadow_emitted = 0; shadow_ovf = 1'b0;
    for (int s = 0; s < sdf_pkg::CacheEntries; s++) begin
      shadow_valid[s] = 1'b0; shadow_seen[s] = 1'b0;
    end
  end

  // watch both channels
  always @(posedge clk_i) begin
    sdf_result_t got, exp_r;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        got.kind = kind_i; got.id = out_id_i;
        got.st = {out_pos_xy_i, out_pos_z_scale_i, out_rot_xy_i, out_rot_zw_i,
                  out_mesh_i, out_tag_i};
        got.cnt = entity_count_i; got.ovf = despawn_overflow_i; got.last = last_i;
        if (expected_results.size() == 0) begin
          fails++;
          $display("%0t: unexpected result kind %0d id %h", $time, kind_i, out_id_i);
        end else begin
          exp_r = expected_results.pop_front();
          if (got.kind != exp_r.kind || got.id != exp_r.id || got.st != exp_r.st ||
              got.cnt != exp_r.cnt || got.ovf != exp_r.ovf || got.last != exp_r.last) begin
            fails++;
            $display("%0t: mismatch expected k%0d id %h cnt %0d ovf %0d last %0d st %h",
                     $time, exp_r.kind, exp_r.id, exp_r.cnt, exp_r.ovf, exp_r.last,
                     exp_r.st);
            $display("%0t:          actual k%0d id %h cnt %0d ovf %0d last %0d st %h",
                     $time, got.kind, got.id, got.cnt, got.ovf, got.last, got.st);
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        filter_item(action_i, net_id_i, in_interest_i, full_req_i,
                    {pos_xy_i, pos_z_scale_i, rot_xy_i, rot_zw_i, mesh_hash_i,
                     user_tag_i});
    end
  end
endmodule

>>> bench/tb_top.sv
// testbench top: stimulus, idling and verdict for the snapshot delta filter
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk, rst_n;
  logic        in_valid, in_stall, action, interest, full_req;
  logic [63:0] net_id, pxy, pzs, rxy, rzw, mesh;
  logic [31:0] tag;
  logic        out_valid, out_stall;
  logic [1:0]  kind;
  logic [63:0] o_id, o_pxy, o_pzs, o_rxy, o_rzw, o_mesh;
  logic [31:0] o_tag;
  logic [15:0] ecount;
  logic        ovf, last;
  int          fails, n_expected;
  bit          quiet;
  logic [63:0] id_pool[64];

  snapshot_delta_filter_core i_dut (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .action_i(action), .net_id_i(net_id), .in_interest_i(interest),
    .full_req_i(full_req), .pos_xy_i(pxy), .pos_z_scale_i(pzs), .rot_xy_i(rxy),
    .rot_zw_i(rzw), .mesh_hash_i(mesh), .user_tag_i(tag),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .kind_o(kind),
    .out_id_o(o_id), .out_pos_xy_o(o_pxy), .out_pos_z_scale_o(o_pzs),
    .out_rot_xy_o(o_rxy), .out_rot_zw_o(o_rzw), .out_mesh_o(o_mesh),
    .out_tag_o(o_tag), .entity_count_o(ecount), .despawn_overflow_o(ovf),
    .last_o(last)
  );

  sdf_checker i_chk (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_i(in_stall),
    .action_i(action), .net_id_i(net_id), .in_interest_i(interest),
    .full_req_i(full_req), .pos_xy_i(pxy), .pos_z_scale_i(pzs), .rot_xy_i(rxy),
    .rot_zw_i(rzw), .mesh_hash_i(mesh), .user_tag_i(tag),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .kind_i(kind),
    .out_id_i(o_id), .out_pos_xy_i(o_pxy), .out_pos_z_scale_i(o_pzs),
    .out_rot_xy_i(o_rxy), .out_rot_zw_i(o_rzw), .out_mesh_i(o_mesh),
    .out_tag_i(o_tag), .entity_count_i(ecount), .despawn_overflow_i(ovf),
    .last_i(last), .fail_count_o(fails), .pending_o(n_expected)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("snapshot_delta_filter_core regression: fail");
    $finish;
  end

  // receiver stalls in random bursts
  initial begin
    int len;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        len = $urandom_range(1, 18);
        out_stall <= 1'b1;
        repeat (len) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // present one item and hold it until taken; valid drops only for idling
  task automatic send_item(logic act, logic [63:0] id, logic intr, logic full,
                           logic [63:0] a, logic [63:0] b, logic [63:0] c,
                           logic [63:0] d, logic [63:0] e, logic [31:0] t);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1; action <= act; net_id <= id; interest <= intr;
    full_req <= full; pxy <= a; pzs <= b; rxy <= c; rzw <= d; mesh <= e; tag <= t;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_record(logic [63:0] id, logic intr, logic full, logic [63:0] v);
    send_item(1'b0, id, intr, full, v, ~v, v ^ 64'h5a5a, v + 1, v << 3, v[31:0]);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  initial begin
    logic [63:0] v;
    int pick;
    quiet = 1'b0;
    rst_n = 1'b0; in_valid = 1'b0; action = 1'b0; net_id = '0; interest = 1'b0;
    full_req = 1'b0; pxy = '0; pzs = '0; rxy = '0; rzw = '0; mesh = '0; tag = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, unchanged, out of interest, sweeps
    send_item(1'b0, '0, 1'b1, 1'b0, '0, '0, '0, '0, '0, '0);
    send_item(1'b0, '1, 1'b1, 1'b0, '1, '1, '1, '1, '1, '1);
    send_item(1'b0, '1, 1'b1, 1'b0, '1, '1, '1, '1, '1, '1);
    send_item(1'b0, '1, 1'b1, 1'b1, '1, '1, '1, '1, '1, '1);
    send_item(1'b0, '1, 1'b1, 1'b0, '1, '1, '1, '1, '1, 32'h7fffffff);
    send_item(1'b0, 64'h55, 1'b0, 1'b1, '1, '0, '1, '0, '1, '1);
    send_item(1'b1, '1, 1'b0, 1'b0, '1, '1, '1, '1, '1, '1);
    send_item(1'b0, '0, 1'b1, 1'b0, '0, '0, '0, '0, '0, '0);
    send_item(1'b1, '0, 1'b1, 1'b0, '0, '0, '0, '0, '0, '0);
    send_item(1'b1, '0, 1'b1, 1'b1, '0, '0, '0, '0, '0, '0);
    // overflow the pending list
    for (int i = 0; i < 40; i++) send_record(64'h1000 + 64'(i), 1'b1, 1'b0, 64'(i));
    send_item(1'b1, '0, 1'b1, 1'b0, '0, '0, '0, '0, '0, '0);
    send_item(1'b1, '0, 1'b1, 1'b0, '0, '0, '0, '0, '0, '0);
    send_item(1'b1, '0, 1'b1, 1'b1, '0, '0, '0, '0, '0, '0);
    send_item(1'b1, '0, 1'b1, 1'b0, '0, '0, '0, '0, '0, '0);

    // random rounds over a small id pool so hits and despawns occur
    for (int i = 0; i < 64; i++) id_pool[i] = (i < 4) ? {60'h0, i[3:0]} : rnd64();
    for (int i = 0; i < 200; i++) begin
      if (i > 170) quiet = 1'b1;
      pick = $urandom_range(0, 63);
      v = (($urandom_range(0, 2) == 0) ? rnd64() : {62'h0, pick[1:0]});
      if ($urandom_range(0, 19) == 0)
        send_item(1'b1, rnd64(), 1'b1, $urandom_range(0, 3) == 0, rnd64(), rnd64(),
                  rnd64(), rnd64(), rnd64(), $urandom);
      else if ($urandom_range(0, 9) == 0)
        send_item(1'b0, rnd64(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), $urandom);
      else
        send_record(id_pool[pick], $urandom_range(0, 7) != 0,
                    $urandom_range(0, 4) == 0, v);
    end
    send_item(1'b1, '0, 1'b1, 1'b1, '0, '0, '0, '0, '0, '0);
    in_valid <= 1'b0;

    // drain then let the block settle
    while (n_expected != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (fails == 0 && n_expected == 0)
      $display("snapshot_delta_filter_core regression: pass");
    else
      $display("snapshot_delta_filter_core regression: fail");
    $finish;
  end
endmodule
